### rtl/core/vtpd_pkg.sv
// Package for the vertex transform with perspective divide.
// Widths, matrix types and shared helper functions; no dependencies.
package vtpd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NUM_REGS  = 8;
  localparam int RIDX_W    = 3;
  localparam int CW        = 32;                 // coordinate width
  localparam int PW        = 2 * CW;             // product width
  localparam int SW        = PW + 2 - FRAC_BITS; // row sum width, signed
  localparam int QW        = 32;                 // quotient bits, one per stage
  localparam int FIFO_D    = 4;
  localparam int FIFO_AW   = 2;

  typedef logic [NUM_REGS-1:0][PW-1:0] mat_t;
  typedef logic [3:0][SW-1:0]          acc_t;  // x', y', z', w sums

  // Matrix entry M[row][col]; col 0..3 is x,y,z,w
  function automatic logic signed [CW-1:0] mat_entry(input mat_t m, input int row,
                                                    input int col);
    logic [PW-1:0] r;
    r = m[2 * col + row / 2];
    return (row % 2 == 1) ? $signed(r[PW-1:CW]) : $signed(r[CW-1:0]);
  endfunction

  // Clamp a row sum to the signed 32-bit range
  function automatic logic [CW:0] clamp_sum(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi, lo;
    hi = SW'(33'sh0_7FFF_FFFF);
    lo = -SW'(33'sh0_8000_0000);
    if (v > hi) return {1'b1, 32'h7FFF_FFFF};
    if (v < lo) return {1'b1, 32'h8000_0000};
    return {1'b0, v[CW-1:0]};
  endfunction

endpackage

### rtl/core/vtpd_cfg.sv
// APB register file holding the 4x4 matrix as eight 64-bit registers.
// Depends on vtpd_pkg.
module vtpd_cfg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [5:0]       paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  output vtpd_pkg::mat_t   mat_o
);
  import vtpd_pkg::*;

  mat_t                mat_q;
  logic [RIDX_W-1:0]   idx;

  assign idx    = paddr[5:3];
  assign pready = 1'b1;
  assign prdata = mat_q[idx];
  assign mat_o  = mat_q;

  // register write on the access cycle; reset gives the identity matrix
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // registers 7 down to 0
      mat_q <= {64'h0001_0000_0000_0000, 64'h0,
                64'h0000_0000_0001_0000, 64'h0,
                64'h0,                   64'h0001_0000_0000_0000,
                64'h0,                   64'h0000_0000_0001_0000};
    end else if (psel && penable && pwrite && pready) begin
      mat_q[idx] <= pwdata;
    end
  end
endmodule

### rtl/core/vtpd_front.sv
// Front end: accepts points, forms the twelve products and the four row sums.
// Depends on vtpd_pkg.
module vtpd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  vtpd_pkg::mat_t  mat_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [95:0]     in_data_i,   // point_x, point_y, point_z
  output logic            push_o,
  input  logic            full_i,
  output vtpd_pkg::acc_t  acc_o
);
  import vtpd_pkg::*;

  logic                      v1_q, v2_q;
  logic signed [PW-1:0]      prod_q [4][3];
  logic signed [CW-1:0]      t_q [4];
  acc_t                      acc_q;
  logic                      adv1, adv2;
  acc_t                      acc_d;

  assign adv2       = !v2_q || !full_i;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;
  assign push_o     = v2_q && !full_i;
  assign acc_o      = acc_q;

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  // stage 1: products, exact
  always_ff @(posedge clk_i) begin
    if (adv1) begin
      for (int c = 0; c < 4; c++) begin
        t_q[c] <= mat_entry(mat_i, 3, c);
        for (int r = 0; r < 3; r++) begin
          prod_q[c][r] <= PW'(mat_entry(mat_i, r, c))
                        * PW'($signed(in_data_i[r*CW +: CW]));
        end
      end
    end
  end

  // stage 2: floor each product to FRAC_BITS and add the translation
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      acc_d[c] = SW'(t_q[c])
               + SW'(prod_q[c][0] >>> FRAC_BITS)
               + SW'(prod_q[c][1] >>> FRAC_BITS)
               + SW'(prod_q[c][2] >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) acc_q <= acc_d;
  end
endmodule

### rtl/core/vtpd_fifo.sv
// Short queue of row sums between front and back end.
// Depends on vtpd_pkg.
module vtpd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  vtpd_pkg::acc_t  wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output vtpd_pkg::acc_t  rdata_o
);
  import vtpd_pkg::*;

  acc_t               mem_q [FIFO_D];
  logic [FIFO_AW-1:0] wp_q, rp_q;
  logic [FIFO_AW:0]   cnt_q;

  assign full_o  = (cnt_q == (FIFO_AW+1)'(FIFO_D));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wdata_i;
  end
endmodule

### rtl/core/vtpd_back.sv
// Back end: three-lane restoring divider, one quotient bit per stage,
// with zero-w bypass and saturation. Depends on vtpd_pkg.
module vtpd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  vtpd_pkg::acc_t  acc_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [95:0]     out_data_o,
  output logic [1:0]      out_user_o
);
  import vtpd_pkg::*;

  localparam int NS = QW;
  localparam int SH = CW - FRAC_BITS;

  logic              v_q    [NS+1];
  logic [SW-1:0]     r_q    [NS+1][3];
  logic [CW-1:0]     nlo_q  [NS+1][3];
  logic [QW-1:0]     q_q    [NS+1][3];
  logic              big_q  [NS+1][3];
  logic              neg_q  [NS+1][3];
  logic [CW:0]       cl_q   [NS+1][3];
  logic [SW-1:0]     d_q    [NS+1];
  logic              wz_q   [NS+1];

  logic              ov_q;
  logic [95:0]       od_q;
  logic [1:0]        ou_q;
  logic              be;

  logic signed [SW-1:0]    w;
  logic [SW-1:0]           mw;
  logic signed [SW-1:0]    a  [3];
  logic [SW-1:0]           ma [3];
  logic [SW+FRAC_BITS-1:0] n  [3];
  logic [SW:0]            rr [NS][3];
  logic                   ge [NS][3];
  logic [95:0]            od_d;
  logic                   sat_d;
  logic [QW-1:0]          qf;

  assign be          = !ov_q || out_ready_i;
  assign pop_o       = be && !empty_i;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  assign out_user_o  = ou_q;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NS; k++) v_q[k] <= 1'b0;
      ov_q <= 1'b0;
    end else if (be) begin
      v_q[0] <= !empty_i;
      for (int k = 0; k < NS; k++) v_q[k+1] <= v_q[k];
      ov_q <= v_q[NS];
    end
  end

  // entry: magnitudes and scaled numerators
  always_comb begin
    w  = $signed(acc_i[3]);
    mw = w[SW-1] ? SW'(-w) : SW'(w);
    for (int l = 0; l < 3; l++) begin
      a[l]  = $signed(acc_i[l]);
      ma[l] = a[l][SW-1] ? SW'(-a[l]) : SW'(a[l]);
      n[l]  = {ma[l], {FRAC_BITS{1'b0}}};
    end
  end

  // divider steps
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      for (int l = 0; l < 3; l++) begin
        rr[k][l] = {r_q[k][l], nlo_q[k][l][CW-1]};
        ge[k][l] = (rr[k][l] >= {1'b0, d_q[k]});
      end
    end
  end

  // entry stage (overflow precheck, zero-w bypass value) and divider stages
  always_ff @(posedge clk_i) begin
    if (be) begin
      d_q[0]  <= mw;
      wz_q[0] <= (w == '0);
      for (int l = 0; l < 3; l++) begin
        r_q[0][l]   <= SW'(n[l][SW+FRAC_BITS-1:CW]);
        nlo_q[0][l] <= n[l][CW-1:0];
        q_q[0][l]   <= '0;
        big_q[0][l] <= ({{SH{1'b0}}, ma[l]} >= {mw, {SH{1'b0}}});
        neg_q[0][l] <= a[l][SW-1] ^ w[SW-1];
        cl_q[0][l]  <= clamp_sum(a[l]);
      end
      for (int k = 0; k < NS; k++) begin
        d_q[k+1]  <= d_q[k];
        wz_q[k+1] <= wz_q[k];
        for (int l = 0; l < 3; l++) begin
          r_q[k+1][l]   <= ge[k][l] ? SW'(rr[k][l] - {1'b0, d_q[k]}) : SW'(rr[k][l]);
          nlo_q[k+1][l] <= {nlo_q[k][l][CW-2:0], 1'b0};
          q_q[k+1][l]   <= {q_q[k][l][QW-2:0], ge[k][l]};
          big_q[k+1][l] <= big_q[k][l];
          neg_q[k+1][l] <= neg_q[k][l];
          cl_q[k+1][l]  <= cl_q[k][l];
        end
      end
    end
  end

  // sign, clamp and select
  always_comb begin
    sat_d = 1'b0;
    od_d  = '0;
    for (int l = 0; l < 3; l++) begin
      qf = q_q[NS][l];
      if (wz_q[NS]) begin
        od_d[l*CW +: CW] = cl_q[NS][l][CW-1:0];
        sat_d = sat_d | cl_q[NS][l][CW];
      end else if (neg_q[NS][l]) begin
        if (big_q[NS][l] || qf > 32'h8000_0000) begin
          od_d[l*CW +: CW] = 32'h8000_0000;
          sat_d = 1'b1;
        end else begin
          od_d[l*CW +: CW] = -qf;
        end
      end else begin
        if (big_q[NS][l] || qf[QW-1]) begin
          od_d[l*CW +: CW] = 32'h7FFF_FFFF;
          sat_d = 1'b1;
        end else begin
          od_d[l*CW +: CW] = qf;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (be) begin
      od_q <= od_d;
      ou_q <= {sat_d, wz_q[NS]};
    end
  end
endmodule

### rtl/core/vertex_transform_perspective_divide.sv
// Top level of the vertex transform with perspective divide.
// Depends on vtpd_pkg, vtpd_cfg, vtpd_front, vtpd_fifo, vtpd_back.
//
// Each point (x, y, z) in signed Q16.16 is multiplied as (x, y, z, 1) by the
// 4x4 matrix in the APB registers (reset: identity), then x', y', z' are
// divided by w. Zero w passes the sums through and sets w_was_zero; any
// clamped result sets saturated. The block takes one point per clock and
// keeps that rate while results are taken. With an empty queue an accepted
// point passes through two front-end stages (multiply, then sum), the queue
// write, the divider entry stage, a 32-stage divider (one quotient bit per
// stage, three lanes sharing the divisor) and the output register. A
// four-entry queue between front and back end absorbs short output stalls.
module vertex_transform_perspective_divide (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // point_x, point_y, point_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,   // out_x, out_y, out_z
  output logic [1:0]   m_axis_tuser    // w_was_zero, saturated
);
  import vtpd_pkg::*;

  mat_t  mat;
  acc_t  f_acc, q_acc;
  logic  push, full, pop, empty;

  vtpd_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .mat_o(mat)
  );

  vtpd_front u_front (
    .clk_i, .rst_ni, .mat_i(mat),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_data_i(s_axis_tdata),
    .push_o(push), .full_i(full), .acc_o(f_acc)
  );

  vtpd_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .wdata_i(f_acc), .full_o(full),
    .pop_i(pop), .empty_o(empty), .rdata_o(q_acc)
  );

  vtpd_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .acc_i(q_acc), .pop_o(pop),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_data_o(m_axis_tdata), .out_user_o(m_axis_tuser)
  );
endmodule

### verif/tb_vertex_transform_perspective_divide.sv
// Testbench for vertex_transform_perspective_divide.
// Drives points over the stream port, programs the matrix over APB and checks
// each output against a behavioral predictor. Depends on vtpd_pkg and the RTL.
`timescale 1ns / 100ps

module tb_vertex_transform_perspective_divide;
  import vtpd_pkg::*;

  typedef struct packed {
    logic [31:0] x, y, z;
    logic        wz, sat;
  } vtx_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  vertex_transform_perspective_divide dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [63:0] matrix_q [NUM_REGS];
  logic [95:0] point_q [$];
  vtx_out_t    vertex_q [$];
  int          errors = 0;
  int          send_idle_pct = 0, recv_stall_pct = 0;
  int          hold_cycles = 0;

  function automatic logic signed [63:0] m_at(int row, int col);
    logic [63:0] r;
    r = matrix_q[2 * col + row / 2];
    return (row % 2) ? 64'($signed(r[63:32])) : 64'($signed(r[31:0]));
  endfunction

  function automatic logic [31:0] sat32(logic signed [127:0] v, ref logic sat);
    if (v > 128'sh7FFF_FFFF) begin
      sat = 1'b1; return 32'h7FFF_FFFF;
    end
    if (v < -128'sh8000_0000) begin
      sat = 1'b1; return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Transform, floor-rounded products, exact sums, truncating divide
  function automatic vtx_out_t transform_point(logic [95:0] pt);
    logic signed [127:0] acc [4];
    logic signed [127:0] prod, num, quo;
    logic signed [63:0]  p [3];
    logic [31:0]         res [3];
    logic                sat;
    vtx_out_t            o;
    sat = 1'b0;
    for (int r = 0; r < 3; r++) p[r] = $signed(pt[32*r +: 32]);
    for (int c = 0; c < 4; c++) begin
      acc[c] = 128'(m_at(3, c));
      for (int r = 0; r < 3; r++) begin
        prod = 128'(m_at(r, c)) * 128'(p[r]);
        acc[c] += prod >>> FRAC_BITS;
      end
    end
    for (int c = 0; c < 3; c++) begin
      if (acc[3] == 0) res[c] = sat32(acc[c], sat);
      else begin
        num = acc[c] <<< FRAC_BITS;
        quo = num / acc[3];
        res[c] = sat32(quo, sat);
      end
    end
    o.x = res[0]; o.y = res[1]; o.z = res[2];
    o.wz = (acc[3] == 0); o.sat = sat;
    return o;
  endfunction

  // Stream driver
  always @(posedge clk_i) begin
    if (!s_axis_tvalid || s_axis_tready) begin
      if (point_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata  <= point_q[0];
        s_axis_tvalid <= 1'b1;
        vertex_q.push_back(transform_point(point_q.pop_front()));
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver stall control, with a counted long hold-off
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles   <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    vtx_out_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
             m_axis_tuser[0], m_axis_tuser[1]};
      if (vertex_q.size() == 0) begin
        $display("%0t: unexpected transaction %h", $time, got);
        errors++;
      end else begin
        want = vertex_q.pop_front();
        if (got.x !== want.x) begin
          $display("%0t: out_x exp %h got %h", $time, want.x, got.x); errors++;
        end
        if (got.y !== want.y) begin
          $display("%0t: out_y exp %h got %h", $time, want.y, got.y); errors++;
        end
        if (got.z !== want.z) begin
          $display("%0t: out_z exp %h got %h", $time, want.z, got.z); errors++;
        end
        if (got.wz !== want.wz) begin
          $display("%0t: w_was_zero exp %b got %b", $time, want.wz, got.wz); errors++;
        end
        if (got.sat !== want.sat) begin
          $display("%0t: saturated exp %b got %b", $time, want.sat, got.sat); errors++;
        end
      end
    end
  end

  task automatic apb_write(int idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 6'(8 * idx); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    matrix_q[idx] = val;
  endtask

  task automatic drain_wait();
    while (point_q.size() > 0 || vertex_q.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(2 ** 22)) - 2 ** 21);
    endcase
  endfunction

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'h0;
      default: return 32'($signed($urandom_range(2 ** 18)) - 2 ** 17);
    endcase
  endfunction

  task automatic load_matrix(int kind);
    for (int i = 0; i < NUM_REGS; i++) begin
      case (kind)
        0: apb_write(i, '0);
        1: apb_write(i, 64'hFFFF_FFFF_FFFF_FFFF);
        2: apb_write(i, 64'h7FFF_FFFF_8000_0000);
        default: apb_write(i, {rand_entry(), rand_entry()});
      endcase
    end
    // Keep w usually nonzero: positive w offset, small positive x and y weights
    if (kind > 3) begin
      apb_write(6, {32'($urandom_range(2 ** 12)), 32'($urandom_range(2 ** 12))});
      apb_write(7, {32'($urandom_range(2 ** 20) + 2 ** 14), rand_entry()});
    end
  endtask

  task automatic random_points(int n);
    for (int i = 0; i < n; i++) point_q.push_back({rand_coord(), rand_coord(), rand_coord()});
  endtask

  initial begin
    matrix_q[0] = 64'd65536;     matrix_q[1] = '0;
    matrix_q[2] = 64'd65536 << 32; matrix_q[3] = '0;
    matrix_q[4] = '0;            matrix_q[5] = 64'd65536;
    matrix_q[6] = '0;            matrix_q[7] = 64'd65536 << 32;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: identity, extremes of coordinates
    point_q.push_back('0);
    point_q.push_back({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    point_q.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    point_q.push_back({32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000});
    point_q.push_back({32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001});
    drain_wait();
    // Zero w: all-zero matrix
    load_matrix(0);
    point_q.push_back({32'h1234_5678, 32'h8765_4321, 32'h7FFF_FFFF});
    point_q.push_back('0);
    drain_wait();
    // All ones: every entry is -1 LSB, so x', y', z' equal w
    load_matrix(1);
    random_points(6);
    drain_wait();
    load_matrix(2);
    random_points(6);
    drain_wait();

    // Random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 8; ph++) begin
      load_matrix(4 + (ph % 3));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      if (ph == 4) hold_cycles = 200;
      random_points(100);
      drain_wait();
    end
    send_idle_pct = 0; recv_stall_pct = 0;
    load_matrix(3);
    random_points(20);
    drain_wait();

    if (errors == 0) $display("tb_vertex_transform_perspective_divide passed");
    else $display("tb_vertex_transform_perspective_divide failed");
    $finish;
  end

  initial begin
    #4ms;
    $display("tb_vertex_transform_perspective_divide failed");
    $finish;
  end
endmodule

### files.f
rtl/core/vtpd_pkg.sv
rtl/core/vtpd_cfg.sv
rtl/core/vtpd_front.sv
rtl/core/vtpd_fifo.sv
rtl/core/vtpd_back.sv
rtl/core/vertex_transform_perspective_divide.sv
verif/tb_vertex_transform_perspective_divide.sv
